// File: rtl/core/random_walk_tail_max_top_assert.svh
// assertion macros used by the checker file
`ifndef RANDOM_WALK_TAIL_MAX_TOP_ASSERT_SVH
`define RANDOM_WALK_TAIL_MAX_TOP_ASSERT_SVH

// same-cycle implication, reset-qualified
`define RWTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, reset-qualified
`define RWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/rwtm_pkg.sv
// shared types, constants and helpers for the random walk tail block
`timescale 1ns / 1ps

package rwtm_pkg;

    localparam int PROB_W = 17;
    localparam int LEAD_W = 10;
    localparam int MASS_W = 32;

    localparam logic [MASS_W-1:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [PROB_W-1:0] ONE_Q16 = 17'h1_0000;

    typedef struct packed {
        logic [PROB_W-1:0] success_prob;
        logic              start_new;
    } in_item_t;

    typedef struct packed {
        logic [MASS_W-1:0] tail_mass;
        logic [MASS_W-1:0] best_mass;
        logic              overflow;
    } out_item_t;

    typedef struct packed {
        logic issue;
        logic first;
        logic calc;
        logic tail_hit;
    } sweep_ctl_t;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              frozen;
    } sweep_cfg_t;

    function automatic logic [MASS_W-1:0] clamp_q31(input logic [MASS_W:0] v);
        logic [MASS_W-1:0] r;
        if (v > {1'b0, ONE_Q31})
        begin
            r = ONE_Q31;
        end
        else
        begin
            r = v[MASS_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/rwtm_store.sv
// distribution store: one read and one write port, registered read with window masking
`timescale 1ns / 1ps

module rwtm_store #(
    parameter int DEPTH = 1025,
    parameter int IW    = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic                      rd_one,
    input  logic [IW-1:0]             rd_addr,
    input  logic                      wr_en,
    input  logic [IW-1:0]             wr_addr,
    input  logic [rwtm_pkg::MASS_W-1:0] wr_data,
    output logic [rwtm_pkg::MASS_W-1:0] rd_data
);

    logic [rwtm_pkg::MASS_W-1:0] mem [DEPTH];
    logic [rwtm_pkg::MASS_W-1:0] raw_reg;
    logic                        live_reg;
    logic                        one_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            one_reg  <= 1'b0;
        end
        else
        begin
            live_reg <= rd_en;
            one_reg  <= rd_one;
        end
    end

    // entries outside the live window read as zero, fresh walk reads one at centre
    assign rd_data = live_reg ? raw_reg : (one_reg ? rwtm_pkg::ONE_Q31 : '0);

endmodule

// File: rtl/core/rwtm_calc.sv
// neighbor update pipeline: products, sum with clamp, tail accumulation
`timescale 1ns / 1ps

module rwtm_calc #(
    parameter int IW = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rwtm_pkg::sweep_ctl_t        ctl,
    input  rwtm_pkg::sweep_cfg_t        cfg,
    input  logic [IW-1:0]               j_addr,
    input  logic [rwtm_pkg::MASS_W-1:0] rd_data,
    output logic                        wr_en,
    output logic [IW-1:0]               wr_addr,
    output logic [rwtm_pkg::MASS_W-1:0] wr_data,
    output logic [rwtm_pkg::MASS_W-1:0] tail_mass,
    output logic                        busy
);

    localparam int PW = rwtm_pkg::MASS_W + rwtm_pkg::PROB_W;

    rwtm_pkg::sweep_ctl_t        ctl1_reg;
    rwtm_pkg::sweep_ctl_t        ctl2_reg;
    logic [IW-1:0]               wa1_reg;
    logic [IW-1:0]               wa2_reg;
    logic [rwtm_pkg::MASS_W-1:0] vm1_reg;
    logic [rwtm_pkg::MASS_W-1:0] v0_reg;
    logic [rwtm_pkg::MASS_W-1:0] up_reg;
    logic [rwtm_pkg::MASS_W-1:0] dn_reg;
    logic [rwtm_pkg::MASS_W-1:0] acc_reg;

    logic [rwtm_pkg::PROB_W-1:0] q_prob;
    logic [PW-1:0]               prod_up;
    logic [PW-1:0]               prod_dn;
    logic [rwtm_pkg::MASS_W-1:0] up_next;
    logic [rwtm_pkg::MASS_W-1:0] dn_next;
    logic [rwtm_pkg::MASS_W-1:0] cell_new;
    logic [rwtm_pkg::MASS_W-1:0] acc_next;

    // stage one: left neighbor times p, right neighbor (fresh read) times 1-p; a frozen walk passes the cell on
    assign q_prob  = rwtm_pkg::ONE_Q16 - cfg.prob;
    assign prod_up = PW'(vm1_reg) * PW'(cfg.prob);
    assign prod_dn = PW'(rd_data) * PW'(q_prob);
    assign up_next = cfg.frozen ? v0_reg : prod_up[rwtm_pkg::MASS_W+15:16];
    assign dn_next = cfg.frozen ? '0 : prod_dn[rwtm_pkg::MASS_W+15:16];

    // stage two: sum, clamp, write back unless frozen, and add cells at or past the lead into the tail
    assign cell_new = rwtm_pkg::clamp_q31({1'b0, up_reg} + {1'b0, dn_reg});
    assign acc_next = rwtm_pkg::clamp_q31({1'b0, acc_reg} + {1'b0, cell_new});

    always_ff @(posedge clk)
    begin
        wa1_reg <= j_addr;
        wa2_reg <= wa1_reg;
        up_reg  <= up_next;
        dn_reg  <= dn_next;
        if (ctl1_reg.issue)
        begin
            vm1_reg <= ctl1_reg.first ? '0 : v0_reg;
            v0_reg  <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            if (ctl1_reg.issue && ctl1_reg.first)
            begin
                acc_reg <= '0;
            end
            else if (ctl2_reg.calc && ctl2_reg.tail_hit)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign wr_en     = ctl2_reg.calc && !cfg.frozen;
    assign wr_addr   = wa2_reg;
    assign wr_data   = cell_new;
    assign tail_mass = acc_reg;
    assign busy      = ctl1_reg.issue || ctl2_reg.calc;

endmodule

// File: rtl/core/random_walk_tail_max_top.sv
// top level: item sequencer, step counter, best tracking and result register
`timescale 1ns / 1ps

// tail probability of a +1/-1 random walk, one result item per input item
// item channel: item_valid/item_ready carry success_prob (Q1.16, clamped to 1.0)
//   and start_new; start_new restarts the walk at offset zero and clears best
// result channel: result_valid/result_ready carry tail_mass, best_mass (Q1.31)
//   and overflow, which is set on every item after the first MAX_STEPS since start
// cfg channel: cfg_valid/cfg_ready write lead_needed; cfg_ready is always high,
//   write only while no item is in flight
// each item sweeps the live part of the distribution memory once, one entry
//   per cycle; after k steps since start that is 2k+3 entries plus one guard read
//   (2k+1 entries plus the guard read when the walk is frozen)
// items are taken one at a time; item_ready rises again as soon as the result
//   is parked in the output register, so a stalled receiver blocks only the
//   finish of the following item
// reset: no clearing pass; the live window is derived from the step count, so
//   entries outside it read as zero and a fresh walk reads 1.0 at the centre;
//   lead_needed resets to 1, best and step count to zero

module random_walk_tail_max_top #(
    parameter int MAX_STEPS = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  rwtm_pkg::in_item_t                item_data,
    output logic                              result_valid,
    input  logic                              result_ready,
    output rwtm_pkg::out_item_t               result_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rwtm_pkg::LEAD_W-1:0]       cfg_data
);

    localparam int DEPTH = 2 * MAX_STEPS + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam int TW    = ((CW > rwtm_pkg::LEAD_W) ? CW : rwtm_pkg::LEAD_W) + 1;
    localparam logic [CW-1:0] CENTRE = CW'(MAX_STEPS);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [rwtm_pkg::LEAD_W-1:0]   lead_reg, lead_next;
    logic [rwtm_pkg::PROB_W-1:0]   prob_reg, prob_next;
    logic                          frozen_reg, frozen_next;
    logic                          kzero_reg, kzero_next;
    logic [SW-1:0]                 steps_reg, steps_next;
    logic [rwtm_pkg::MASS_W-1:0]   best_reg, best_next;
    logic [CW-1:0]                 addr_reg, addr_next;
    logic [CW-1:0]                 lo_reg, lo_next;
    logic [CW-1:0]                 end_reg, end_next;
    logic [CW-1:0]                 win_lo_reg, win_lo_next;
    logic [CW-1:0]                 win_hi_reg, win_hi_next;
    logic [TW-1:0]                 thr_reg, thr_next;
    logic                          out_valid_reg, out_valid_next;
    rwtm_pkg::out_item_t           out_item_reg, out_item_next;

    logic                          item_acc;
    logic                          cfg_acc;
    logic [CW-1:0]                 k_cur;
    logic                          frozen_now;
    logic [CW-1:0]                 j_cur;
    logic                          rd_en;
    logic                          rd_one;
    logic [rwtm_pkg::MASS_W-1:0]   rd_data;
    logic                          wr_en;
    logic [IW-1:0]                 wr_addr;
    logic [rwtm_pkg::MASS_W-1:0]   wr_data;
    logic [rwtm_pkg::MASS_W-1:0]   tail_mass;
    logic                          calc_busy;
    logic [rwtm_pkg::MASS_W-1:0]   best_cand;
    rwtm_pkg::sweep_ctl_t          ctl;
    rwtm_pkg::sweep_cfg_t          scfg;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_acc     = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign cfg_acc      = cfg_valid && cfg_ready;
    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

    // step count before this item sets the old window
    assign k_cur      = CW'(steps_reg);
    assign frozen_now = (steps_reg >= SW'(MAX_STEPS));
    assign j_cur      = addr_reg - CW'(1);
    assign best_cand  = (tail_mass > best_reg) ? tail_mass : best_reg;

    assign scfg.prob   = prob_reg;
    assign scfg.frozen = frozen_reg;

    always_comb
    begin
        state_next     = state_reg;
        lead_next      = cfg_acc ? cfg_data : lead_reg;
        prob_next      = prob_reg;
        frozen_next    = frozen_reg;
        kzero_next     = kzero_reg;
        steps_next     = steps_reg;
        best_next      = best_reg;
        addr_next      = addr_reg;
        lo_next        = lo_reg;
        end_next       = end_reg;
        win_lo_next    = win_lo_reg;
        win_hi_next    = win_hi_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_item_next  = out_item_reg;
        ctl            = '0;
        rd_en          = 1'b0;
        rd_one         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    prob_next = (item_data.success_prob > rwtm_pkg::ONE_Q16) ?
                                rwtm_pkg::ONE_Q16 : item_data.success_prob;
                    if (item_data.start_new)
                    begin
                        steps_next = '0;
                        best_next  = '0;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                // update sweeps the new window, a frozen walk the old one
                frozen_next = frozen_now;
                kzero_next  = (steps_reg == '0);
                win_lo_next = CENTRE - k_cur;
                win_hi_next = CENTRE + k_cur;
                lo_next     = CENTRE - k_cur - (frozen_now ? CW'(0) : CW'(1));
                end_next    = CENTRE + k_cur + (frozen_now ? CW'(1) : CW'(2));
                addr_next   = CENTRE - k_cur - (frozen_now ? CW'(0) : CW'(1));
                thr_next    = TW'(CENTRE) + TW'(lead_reg);
                if (!frozen_now)
                begin
                    steps_next = steps_reg + SW'(1);
                end
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                ctl.issue    = 1'b1;
                ctl.first    = (addr_reg == lo_reg);
                ctl.calc     = (addr_reg != lo_reg);
                ctl.tail_hit = (addr_reg != lo_reg) && (TW'(j_cur) >= thr_reg);
                rd_en        = !kzero_reg && (addr_reg >= win_lo_reg) &&
                               (addr_reg <= win_hi_reg);
                rd_one       = kzero_reg && (addr_reg == CENTRE);
                if (addr_reg == end_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!calc_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || result_ready)
                begin
                    best_next               = best_cand;
                    out_item_next.tail_mass = tail_mass;
                    out_item_next.best_mass = best_cand;
                    out_item_next.overflow  = frozen_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lead_reg      <= rwtm_pkg::LEAD_W'(1);
            steps_reg     <= '0;
            best_reg      <= '0;
            frozen_reg    <= 1'b0;
            kzero_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lead_reg      <= lead_next;
            steps_reg     <= steps_next;
            best_reg      <= best_next;
            frozen_reg    <= frozen_next;
            kzero_reg     <= kzero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prob_reg     <= prob_next;
        addr_reg     <= addr_next;
        lo_reg       <= lo_next;
        end_reg      <= end_next;
        win_lo_reg   <= win_lo_next;
        win_hi_reg   <= win_hi_next;
        thr_reg      <= thr_next;
        out_item_reg <= out_item_next;
    end

    rwtm_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_one  (rd_one),
        .rd_addr (addr_reg[IW-1:0]),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    rwtm_calc #(
        .IW (IW)
    ) u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg       (scfg),
        .j_addr    (j_cur[IW-1:0]),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .tail_mass (tail_mass),
        .busy      (calc_busy)
    );

endmodule

// File: rtl/core/rwtm_checker.sv
// port-level checker for the random walk tail block and its bind
`timescale 1ns / 1ps
`include "random_walk_tail_max_top_assert.svh"

module rwtm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input rwtm_pkg::out_item_t result_data
);

    // one item in flight: ready drops right after an accept
    `RWTM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, item_valid && item_ready, !item_ready)

    // a stalled result holds
    `RWTM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_data))

    // best is a running maximum of the tail
    `RWTM_ASSERT_NOW(a_best_covers_tail, clk, rst_n, result_valid, result_data.tail_mass <= result_data.best_mass)

    // best mass never exceeds one
    `RWTM_ASSERT_NOW(a_best_bounded, clk, rst_n, result_valid, result_data.best_mass <= rwtm_pkg::ONE_Q31)

endmodule

bind random_walk_tail_max_top rwtm_checker u_rwtm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);
